[rtl/l2lf_pkg.sv]
// ----------------------------------------------------------------------------
// l2lf_pkg
// shared types and constants of the layer-2 learning forwarder
// ----------------------------------------------------------------------------
package l2lf_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 256;
    localparam int unsigned NUM_PORTS_DEF     = 8;
    localparam int unsigned MAC_W             = 48;
    localparam int unsigned PORT_W            = 3;
    localparam int unsigned STAMP_W           = 32;
    localparam int unsigned CFG_W             = 16;
    localparam int unsigned MASK_W            = 8;
    localparam int unsigned PADDR_W           = 3;
    localparam int unsigned PDATA_W           = 32;
    localparam int unsigned MCAST_BIT         = 40;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_AGING_TIME     = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_CHECK_INTERVAL = 3'd4;

    localparam logic [CFG_W-1:0] AGING_TIME_RST     = 16'd300;
    localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = 16'd10;

    typedef enum logic [1:0] {
        DEC_MCAST    = 2'd0,
        DEC_UNKNOWN  = 2'd1,
        DEC_UNICAST  = 2'd2,
        DEC_FILTERED = 2'd3
    } decision_t;

    typedef struct packed {
        logic              opcode;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] ingress_port;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        logic [1:0]        decision;
    } out_item_t;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEARN,
        ST_WRITE,
        ST_SWEEP,
        ST_LOOK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic tick;
        logic capture;
        logic scan_clear;
        logic scan_run;
        logic key_dst;
        logic learn_write;
        logic sweep_en;
        logic sweep_end;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic hit;
        logic last;
        logic sweep_due;
        logic mcast;
        logic out_free;
    } status_t;

endpackage

[rtl/l2lf_ram.sv]
// ----------------------------------------------------------------------------
// l2lf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module l2lf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/l2lf_ctrl.sv]
// ----------------------------------------------------------------------------
// l2lf_ctrl
// frame sequencer: learn scan, learn write, aging sweep, lookup, result
// ----------------------------------------------------------------------------
module l2lf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  l2lf_pkg::status_t sts,
    output l2lf_pkg::cmd_t    cmd
);
    import l2lf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !sts.in_tick) state_next = ST_LEARN;
            end
            ST_LEARN: begin
                if (sts.hit || sts.last) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (sts.sweep_due) state_next = ST_SWEEP;
                else if (sts.mcast) state_next = ST_RESULT;
                else state_next = ST_LOOK;
            end
            ST_SWEEP: begin
                if (sts.last) state_next = sts.mcast ? ST_RESULT : ST_LOOK;
            end
            ST_LOOK: begin
                if (sts.hit || sts.last) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.tick       = s_valid && sts.in_tick;
                cmd.capture    = s_valid && !sts.in_tick;
                cmd.scan_clear = s_valid && !sts.in_tick;
            end
            ST_LEARN: begin
                cmd.scan_run = 1'b1;
            end
            ST_WRITE: begin
                cmd.learn_write = 1'b1;
                cmd.scan_clear  = 1'b1;
            end
            ST_SWEEP: begin
                cmd.scan_run   = 1'b1;
                cmd.sweep_en   = 1'b1;
                cmd.sweep_end  = sts.last;
                cmd.scan_clear = sts.last;
            end
            ST_LOOK: begin
                cmd.scan_run = 1'b1;
                cmd.key_dst  = 1'b1;
            end
            ST_RESULT: begin
                cmd.load_out = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end
endmodule

[rtl/l2lf_dp.sv]
// ----------------------------------------------------------------------------
// l2lf_dp
// table scan datapath, valid map, tick counters and result register
// ----------------------------------------------------------------------------
module l2lf_dp #(
    parameter int unsigned TABLE_ENTRIES = l2lf_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned NUM_PORTS     = l2lf_pkg::NUM_PORTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  l2lf_pkg::in_item_t              s_data,
    input  logic [l2lf_pkg::CFG_W-1:0]      aging_time,
    input  logic [l2lf_pkg::CFG_W-1:0]      check_interval,
    input  l2lf_pkg::cmd_t                  cmd,
    output l2lf_pkg::status_t               sts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output l2lf_pkg::out_item_t             m_data
);
    import l2lf_pkg::*;

    localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W    = IDX_W + 1;
    localparam int unsigned SET_N    = (NUM_PORTS < MASK_W) ? NUM_PORTS : MASK_W;
    localparam logic [MASK_W-1:0] PORT_SET = MASK_W'((2 ** SET_N) - 1);
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    in_item_t           item_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [STAMP_W-1:0] last_reg;
    logic               valid_reg [TABLE_ENTRIES];
    logic [CNT_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [PORT_W-1:0]  hit_port_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic               issue;
    logic               cur_valid;
    logic [MAC_W-1:0]   key;
    logic               hit;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [STAMP_W-1:0] age;
    logic               expired;
    logic [MASK_W-1:0]  flood;
    out_item_t          result;

    l2lf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_entry  = entry_t'(rd_word);
    assign issue     = cmd.scan_run && (addr_reg < CNT_END);
    assign cur_valid = valid_reg[rd_idx_reg];
    assign key       = cmd.key_dst ? item_reg.dst_mac : item_reg.src_mac;
    assign hit       = rd_vld_reg && cur_valid && (rd_entry.mac == key);
    assign we        = cmd.learn_write && (hit_found_reg || free_found_reg);
    assign waddr     = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign age       = now_reg - rd_entry.stamp;
    assign expired   = age > STAMP_W'(aging_time);

    always_comb begin
        wr_entry.mac   = item_reg.src_mac;
        wr_entry.port  = item_reg.ingress_port;
        wr_entry.stamp = now_reg;
    end

    assign sts.in_tick   = (s_data.opcode == OP_TICK);
    assign sts.hit       = hit;
    assign sts.last      = rd_vld_reg && (rd_idx_reg == IDX_LAST);
    assign sts.sweep_due = (now_reg - last_reg) >= STAMP_W'(check_interval);
    assign sts.mcast     = item_reg.dst_mac[MCAST_BIT];
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        flood = PORT_SET & ~(MASK_W'(1) << item_reg.ingress_port);
        if (item_reg.dst_mac[MCAST_BIT]) begin
            result.egress_mask = flood;
            result.decision    = DEC_MCAST;
        end else if (!hit_found_reg) begin
            result.egress_mask = flood;
            result.decision    = DEC_UNKNOWN;
        end else if (hit_port_reg == item_reg.ingress_port) begin
            result.egress_mask = '0;
            result.decision    = DEC_FILTERED;
        end else begin
            result.egress_mask = (MASK_W'(1) << hit_port_reg) & PORT_SET;
            result.decision    = DEC_UNICAST;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.load_out) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg        <= '0;
            last_reg       <= '0;
            addr_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_port_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.tick) begin
                now_reg <= now_reg + STAMP_W'(1);
            end
            if (cmd.sweep_end) begin
                last_reg <= now_reg;
            end
            if (cmd.scan_clear) begin
                addr_reg       <= '0;
                rd_vld_reg     <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                rd_vld_reg <= issue;
                if (issue) begin
                    addr_reg   <= addr_reg + CNT_W'(1);
                    rd_idx_reg <= addr_reg[IDX_W-1:0];
                end
                if (hit && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                    hit_port_reg  <= rd_entry.port;
                end
                if (rd_vld_reg && !cur_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end
            if (cmd.learn_write && !hit_found_reg && free_found_reg) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.sweep_en && rd_vld_reg && cur_valid && expired) begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

[rtl/l2_learning_forwarder.sv]
// ----------------------------------------------------------------------------
// l2_learning_forwarder
// learning layer-2 bridge with aging: source learning, table aging, forwarding
// ----------------------------------------------------------------------------
// A tick word only advances the seconds counter. A frame word is accepted,
// then walks the forwarding table through its single read port, one entry
// per cycle: a learn scan (shorter on a hit), a write step, an aging sweep
// of the whole table when the check interval has passed, a lookup scan for
// a unicast destination (shorter on a hit), and the load of the result
// register, which waits while an earlier result still waits there. The
// result register lets the next word be accepted while a result still
// waits.
module l2_learning_forwarder #(
    parameter int unsigned TABLE_ENTRIES = l2lf_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned NUM_PORTS     = l2lf_pkg::NUM_PORTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  l2lf_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output l2lf_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [l2lf_pkg::PADDR_W-1:0]  paddr,
    input  logic [l2lf_pkg::PDATA_W-1:0]  pwdata,
    output logic [l2lf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import l2lf_pkg::*;

    logic [CFG_W-1:0] aging_time_reg;
    logic [CFG_W-1:0] check_interval_reg;
    logic             wr_en;
    cmd_t             cmd;
    status_t          sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aging_time_reg     <= AGING_TIME_RST;
            check_interval_reg <= CHECK_INTERVAL_RST;
        end else if (wr_en) begin
            if (paddr == ADDR_AGING_TIME) aging_time_reg <= pwdata[CFG_W-1:0];
            if (paddr == ADDR_CHECK_INTERVAL) check_interval_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        priority if (paddr == ADDR_AGING_TIME) begin
            prdata = PDATA_W'(aging_time_reg);
        end else if (paddr == ADDR_CHECK_INTERVAL) begin
            prdata = PDATA_W'(check_interval_reg);
        end else begin
            prdata = '0;
        end
    end

    l2lf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    l2lf_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data         (s_data),
        .aging_time     (aging_time_reg),
        .check_interval (check_interval_reg),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );
endmodule
